### src/cbez_pkg.sv
package cbez_pkg;

	// Fixed-point formats of the control points and of the curve parameter.
	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;

	// Derived widths.
	localparam int TW = T_FRAC_BITS + 1;   // t, s and the basis terms (0 .. 1.0)
	localparam int PW = 2 * TW;            // product of two basis terms
	localparam int WW = TW + 2;            // Bernstein weight including the factor three
	localparam int DW = COORD_BITS + 1;    // difference of two control points
	localparam int TB = COORD_BITS + 3;    // tangent output width

	// Register file layout.
	localparam int NUM_REGS = 8;
	localparam int IDX_W    = $clog2(NUM_REGS);

	localparam logic [IDX_W-1:0] REG_P0_X = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_P0_Y = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_P1_X = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_P1_Y = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_P2_X = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_P2_Y = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_P3_X = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_P3_Y = IDX_W'(7);

	// Constants of the arithmetic.
	localparam logic [TW-1:0]        T_ONE   = TW'(1) << T_FRAC_BITS;
	localparam logic signed [TB-1:0] TAN_LIM = TB'(3) << COORD_BITS;

	// Number of register stages in each coordinate lane.
	localparam int LANE_STAGES = 5;

	// Basis values of one item, as handed from the weight unit to the lanes.
	typedef struct packed {
		logic [WW-1:0] w0;
		logic [WW-1:0] w1;
		logic [WW-1:0] w2;
		logic [WW-1:0] w3;
		logic [TW-1:0] s2;
		logic [TW-1:0] st;
		logic [TW-1:0] t2;
	} wgt_t;

	// Control points of one axis and their successive differences.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] p0;
		logic signed [COORD_BITS-1:0] p1;
		logic signed [COORD_BITS-1:0] p2;
		logic signed [COORD_BITS-1:0] p3;
		logic signed [DW-1:0]         d1;
		logic signed [DW-1:0]         d2;
		logic signed [DW-1:0]         d3;
	} axis_t;

	// Round an unsigned product of two basis terms back to Q1.F, half up.
	function automatic logic [TW-1:0] rnd_q(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = p + (PW'(1) << (T_FRAC_BITS - 1));
		return r[T_FRAC_BITS+TW-1:T_FRAC_BITS];
	endfunction

endpackage

### src/cbez_regs.sv
module cbez_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cbez_pkg::IDX_W-1:0]      cfg_index,
	input  logic [cbez_pkg::COORD_BITS-1:0] cfg_data,
	output cbez_pkg::axis_t                 ax_x,
	output cbez_pkg::axis_t                 ax_y
);
	import cbez_pkg::*;

	logic signed [COORD_BITS-1:0] p_q [NUM_REGS];
	logic signed [DW-1:0]         dx1_q, dx2_q, dx3_q;
	logic signed [DW-1:0]         dy1_q, dy2_q, dy3_q;

	// Control point registers, written one at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				p_q[i] <= '0;
			end
		end else if (cfg_we) begin
			p_q[cfg_index] <= $signed(cfg_data);
		end
	end

	// Point differences for the tangent, kept registered so that the lanes
	// see no subtractor in front of their multipliers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx1_q <= '0;
			dx2_q <= '0;
			dx3_q <= '0;
			dy1_q <= '0;
			dy2_q <= '0;
			dy3_q <= '0;
		end else begin
			dx1_q <= DW'(p_q[REG_P1_X]) - DW'(p_q[REG_P0_X]);
			dx2_q <= DW'(p_q[REG_P2_X]) - DW'(p_q[REG_P1_X]);
			dx3_q <= DW'(p_q[REG_P3_X]) - DW'(p_q[REG_P2_X]);
			dy1_q <= DW'(p_q[REG_P1_Y]) - DW'(p_q[REG_P0_Y]);
			dy2_q <= DW'(p_q[REG_P2_Y]) - DW'(p_q[REG_P1_Y]);
			dy3_q <= DW'(p_q[REG_P3_Y]) - DW'(p_q[REG_P2_Y]);
		end
	end

	// Per-axis views for the two lanes.
	always_comb begin
		ax_x.p0 = p_q[REG_P0_X];
		ax_x.p1 = p_q[REG_P1_X];
		ax_x.p2 = p_q[REG_P2_X];
		ax_x.p3 = p_q[REG_P3_X];
		ax_x.d1 = dx1_q;
		ax_x.d2 = dx2_q;
		ax_x.d3 = dx3_q;
		ax_y.p0 = p_q[REG_P0_Y];
		ax_y.p1 = p_q[REG_P1_Y];
		ax_y.p2 = p_q[REG_P2_Y];
		ax_y.p3 = p_q[REG_P3_Y];
		ax_y.d1 = dy1_q;
		ax_y.d2 = dy2_q;
		ax_y.d3 = dy3_q;
	end

endmodule

### src/cbez_weights.sv
module cbez_weights (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [cbez_pkg::TW-1:0] t,
	output logic                    wgt_valid,
	input  logic                    wgt_stall,
	output cbez_pkg::wgt_t          wgt
);
	import cbez_pkg::*;

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic          en_s1, en_s2, en_s3, en_s4;
	logic [TW-1:0] t_cl;
	logic [TW-1:0] t_s1, s_s1;
	logic [TW-1:0] t_s2, s_s2, s2_s2, st_s2, t2_s2;
	logic [TW-1:0] w0_s3, w1_s3, w2_s3, w3_s3, s2_s3, st_s3, t2_s3;
	wgt_t          wgt_s4;

	// A stage takes a new item when it is empty or its successor moves on.
	assign en_s4    = !vld_s4 || !wgt_stall;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	// Parameters above one are treated as one.
	assign t_cl = (t > T_ONE) ? T_ONE : t;

	// Stage 1: clamp t and form s = 1 - t.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			t_s1 <= t_cl;
			s_s1 <= T_ONE - t_cl;
		end
	end

	// Stage 2: second-order terms s^2, s*t and t^2.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			t_s2  <= t_s1;
			s_s2  <= s_s1;
			s2_s2 <= rnd_q(PW'(s_s1) * PW'(s_s1));
			st_s2 <= rnd_q(PW'(s_s1) * PW'(t_s1));
			t2_s2 <= rnd_q(PW'(t_s1) * PW'(t_s1));
		end
	end

	// Stage 3: third-order Bernstein terms, before the factor three.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			w0_s3 <= rnd_q(PW'(s2_s2) * PW'(s_s2));
			w1_s3 <= rnd_q(PW'(s2_s2) * PW'(t_s2));
			w2_s3 <= rnd_q(PW'(s_s2) * PW'(t2_s2));
			w3_s3 <= rnd_q(PW'(t2_s2) * PW'(t_s2));
			s2_s3 <= s2_s2;
			st_s3 <= st_s2;
			t2_s3 <= t2_s2;
		end
	end

	// Stage 4: apply the factor three to the two middle weights.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			wgt_s4.w0 <= WW'(w0_s3);
			wgt_s4.w1 <= WW'(w1_s3) + (WW'(w1_s3) << 1);
			wgt_s4.w2 <= WW'(w2_s3) + (WW'(w2_s3) << 1);
			wgt_s4.w3 <= WW'(w3_s3);
			wgt_s4.s2 <= s2_s3;
			wgt_s4.st <= st_s3;
			wgt_s4.t2 <= t2_s3;
		end
	end

	assign wgt_valid = vld_s4;
	assign wgt       = wgt_s4;

endmodule

### src/cbez_lane.sv
module cbez_lane (
	input  logic                                   clk,
	input  logic [cbez_pkg::LANE_STAGES-1:0]       en,
	input  cbez_pkg::wgt_t                         wgt,
	input  cbez_pkg::axis_t                        ax,
	output logic signed [cbez_pkg::COORD_BITS-1:0] pos,
	output logic signed [cbez_pkg::TB-1:0]         tan
);
	import cbez_pkg::*;

	localparam int PROD_W = WW + 1 + COORD_BITS;  // weight times control point
	localparam int TQ_W   = TW + 1 + DW;          // basis term times difference
	localparam int POS_W  = PROD_W + 2;           // sum of four weighted points
	localparam int TAN_W  = TQ_W + 3;             // derivative sum before the factor three
	localparam int TAN3_W = TAN_W + 2;
	localparam int PR_W   = POS_W - T_FRAC_BITS;
	localparam int TR_W   = TAN3_W - T_FRAC_BITS;

	localparam logic signed [POS_W-1:0]  POS_HALF = POS_W'(1) << (T_FRAC_BITS - 1);
	localparam logic signed [TAN3_W-1:0] TAN_HALF = TAN3_W'(1) << (T_FRAC_BITS - 1);
	localparam logic signed [PR_W-1:0]   POS_HI   =
		PR_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [PR_W-1:0]   POS_LO   = PR_W'(-(64'sd1 <<< (COORD_BITS - 1)));
	localparam logic signed [TR_W-1:0]   TAN_HI   = TR_W'(TAN_LIM);
	localparam logic signed [TR_W-1:0]   TAN_LO   = -TR_W'(TAN_LIM);

	logic signed [WW:0]             w0s, w1s, w2s, w3s;
	logic signed [TW:0]             s2s, sts, t2s;
	logic signed [PROD_W-1:0]       m0_s1, m1_s1, m2_s1, m3_s1;
	logic signed [TQ_W-1:0]         q1_s1, q2_s1, q3_s1;
	logic signed [POS_W-1:0]        pos_a_s2, pos_b_s2, pos_sum_s3;
	logic signed [TAN_W-1:0]        tan_a_s2, tan_b_s2, tan_sum_s3;
	logic signed [POS_W-1:0]        pos_r;
	logic signed [PR_W-1:0]         pos_f, pos_c;
	logic signed [COORD_BITS-1:0]   pos_s4, pos_s5;
	logic signed [TAN3_W-1:0]       tan3_s4, tan_r;
	logic signed [TR_W-1:0]         tan_f, tan_c;
	logic signed [TB-1:0]           tan_s5;

	// The basis values are unsigned; widen them by a zero sign bit.
	assign w0s = $signed({1'b0, wgt.w0});
	assign w1s = $signed({1'b0, wgt.w1});
	assign w2s = $signed({1'b0, wgt.w2});
	assign w3s = $signed({1'b0, wgt.w3});
	assign s2s = $signed({1'b0, wgt.s2});
	assign sts = $signed({1'b0, wgt.st});
	assign t2s = $signed({1'b0, wgt.t2});

	// Stage 1: all products of this axis.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			m0_s1 <= w0s * ax.p0;
			m1_s1 <= w1s * ax.p1;
			m2_s1 <= w2s * ax.p2;
			m3_s1 <= w3s * ax.p3;
			q1_s1 <= s2s * ax.d1;
			q2_s1 <= sts * ax.d2;
			q3_s1 <= t2s * ax.d3;
		end
	end

	// Stage 2: first level of the adder trees; the middle tangent term is doubled.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pos_a_s2 <= POS_W'(m0_s1) + POS_W'(m1_s1);
			pos_b_s2 <= POS_W'(m2_s1) + POS_W'(m3_s1);
			tan_a_s2 <= TAN_W'(q1_s1) + (TAN_W'(q2_s1) <<< 1);
			tan_b_s2 <= TAN_W'(q3_s1);
		end
	end

	// Stage 3: final sums.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			pos_sum_s3 <= pos_a_s2 + pos_b_s2;
			tan_sum_s3 <= tan_a_s2 + tan_b_s2;
		end
	end

	// Position rounding (half up, then floor) and saturation to the coordinate range.
	assign pos_r = pos_sum_s3 + POS_HALF;
	assign pos_f = pos_r[POS_W-1:T_FRAC_BITS];
	assign pos_c = (pos_f > POS_HI) ? POS_HI : ((pos_f < POS_LO) ? POS_LO : pos_f);

	// Stage 4: position done; the tangent sum gets its factor three.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			pos_s4  <= pos_c[COORD_BITS-1:0];
			tan3_s4 <= TAN3_W'(tan_sum_s3) + (TAN3_W'(tan_sum_s3) <<< 1);
		end
	end

	// Tangent rounding and saturation to plus or minus three units of range.
	assign tan_r = tan3_s4 + TAN_HALF;
	assign tan_f = tan_r[TAN3_W-1:T_FRAC_BITS];
	assign tan_c = (tan_f > TAN_HI) ? TAN_HI : ((tan_f < TAN_LO) ? TAN_LO : tan_f);

	// Stage 5: output register.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			pos_s5 <= pos_s4;
			tan_s5 <= tan_c[TB-1:0];
		end
	end

	assign pos = pos_s5;
	assign tan = tan_s5;

endmodule

### src/cubic_bezier_point_tangent_core.sv
// Cubic Bezier point and tangent evaluator. Load the four control points
// (signed Q8.8, registers 0 to 7 in the order p0_x, p0_y .. p3_x, p3_y) through
// the configuration port while no item is in flight; that port is always
// ready. Each item carries t in unsigned Q1.16 (values above 1.0 count as
// 1.0) and returns one result with the curve point and its first derivative,
// both rounded half up, the point saturated to 16 bits and the derivative to
// plus or minus 196608. The block accepts one item per clock unless the
// pipeline is full and the output stalled; four stages build the Bernstein
// weights, then five stages in each axis lane form the products, the adder
// trees and the rounding. Each stage holds its item only while the next one is
// full and stalled, so bubbles close up and a stalled output does not stop
// new items until the whole pipeline is full.
module cubic_bezier_point_tangent_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [cbez_pkg::TW-1:0]                t,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [cbez_pkg::COORD_BITS-1:0] pos_x,
	output logic signed [cbez_pkg::COORD_BITS-1:0] pos_y,
	output logic signed [cbez_pkg::TB-1:0]         tan_x,
	output logic signed [cbez_pkg::TB-1:0]         tan_y,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [cbez_pkg::IDX_W-1:0]             cfg_index,
	input  logic [cbez_pkg::COORD_BITS-1:0]        cfg_data
);
	import cbez_pkg::*;

	axis_t                  ax_x, ax_y;
	wgt_t                   wgt;
	logic                   wgt_valid, wgt_stall;
	logic [LANE_STAGES-1:0] lane_vld_q;
	logic [LANE_STAGES-1:0] lane_en;

	assign cfg_ready = 1'b1;

	cbez_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ax_x      (ax_x),
		.ax_y      (ax_y)
	);

	cbez_weights u_weights (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.t         (t),
		.wgt_valid (wgt_valid),
		.wgt_stall (wgt_stall),
		.wgt       (wgt)
	);

	// Lane stage enables: a stage moves when it is empty or its successor moves.
	always_comb begin
		lane_en[LANE_STAGES-1] = !lane_vld_q[LANE_STAGES-1] || !out_stall;
		for (int k = LANE_STAGES - 2; k >= 0; k--) begin
			lane_en[k] = !lane_vld_q[k] || lane_en[k+1];
		end
	end

	assign wgt_stall = !lane_en[0];

	// Valid bits that travel alongside the two lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_vld_q <= '0;
		end else begin
			if (lane_en[0]) lane_vld_q[0] <= wgt_valid;
			for (int k = 1; k < LANE_STAGES; k++) begin
				if (lane_en[k]) lane_vld_q[k] <= lane_vld_q[k-1];
			end
		end
	end

	cbez_lane u_lane_x (
		.clk (clk),
		.en  (lane_en),
		.wgt (wgt),
		.ax  (ax_x),
		.pos (pos_x),
		.tan (tan_x)
	);

	cbez_lane u_lane_y (
		.clk (clk),
		.en  (lane_en),
		.wgt (wgt),
		.ax  (ax_y),
		.pos (pos_y),
		.tan (tan_y)
	);

	assign out_valid = lane_vld_q[LANE_STAGES-1];

endmodule

### src/cbez_checker.sv
module cbez_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic signed [cbez_pkg::COORD_BITS-1:0] pos_x,
	input logic signed [cbez_pkg::COORD_BITS-1:0] pos_y,
	input logic signed [cbez_pkg::TB-1:0]         tan_x,
	input logic signed [cbez_pkg::TB-1:0]         tan_y
);
	import cbez_pkg::*;

	localparam logic signed [TB-1:0] TAN_NEG = -TAN_LIM;

	// The derivative never leaves its saturation range.
	a_tan_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tan_x <= TAN_LIM && tan_x >= TAN_NEG))
		else $error("tan_x outside its saturation range");

	a_tan_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tan_y <= TAN_LIM && tan_y >= TAN_NEG))
		else $error("tan_y outside its saturation range");

	// With no result waiting the pipeline cannot be full, so input is taken.
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled although no result is waiting");

	// A stalled result is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(tan_x) && $stable(tan_y))
		else $error("stalled result changed or vanished");

endmodule

bind cubic_bezier_point_tangent_core cbez_checker u_cbez_checker (.*);
